@@ sv/vcfb_pkg.sv @@
// Package for the voxel cube frame buffer.
// Holds operation codes, address-select codes and the controller/datapath structs.
// No dependencies.
package vcfb_pkg;

    localparam int VCFB_CUBE_SIZE = 9;
    localparam int VCFB_WORD_BITS = 16;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_TOGGLE = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_RAW    = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_SEND   = 3'd5;

    localparam logic [1:0] ASEL_VOXEL = 2'd0;
    localparam logic [1:0] ASEL_RAW   = 2'd1;
    localparam logic [1:0] ASEL_CLEAR = 2'd2;
    localparam logic [1:0] ASEL_SEND  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       wr_en;
        logic [1:0] addr_sel;
        logic       cnt_step;
        logic       emit_read;
        logic       emit_word;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       voxel_ok;
        logic       raw_ok;
        logic       send_ok;
        logic       clr_done;
        logic       send_done;
    } t_status;

endpackage

@@ sv/vcfb_ctrl.sv @@
// Controller state machine for the voxel cube frame buffer.
// Depends on vcfb_pkg; drives the datapath through t_cmd and reads t_status.
module vcfb_ctrl
    import vcfb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_MODIFY   = 3'd2;
    localparam logic [2:0] S_READ_OUT = 3'd3;
    localparam logic [2:0] S_CLR_RD   = 3'd4;
    localparam logic [2:0] S_CLR_WR   = 3'd5;
    localparam logic [2:0] S_SEND     = 3'd6;
    localparam logic [2:0] S_SEND_END = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.op)
                    OP_WRITE, OP_TOGGLE: begin
                        o_cmd.addr_sel = ASEL_VOXEL;
                        if (i_status.voxel_ok) begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_MODIFY;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    OP_READ: begin
                        o_cmd.addr_sel = ASEL_VOXEL;
                        o_cmd.rd_en    = i_status.voxel_ok;
                        n_state        = S_READ_OUT;
                    end
                    OP_RAW: begin
                        o_cmd.addr_sel = ASEL_RAW;
                        o_cmd.wr_en    = i_status.raw_ok;
                        n_state        = S_IDLE;
                    end
                    OP_CLEAR: begin
                        n_state = S_CLR_RD;
                    end
                    OP_SEND: begin
                        o_cmd.addr_sel = ASEL_SEND;
                        if (i_status.send_ok) begin
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.cnt_step = 1'b1;
                            n_state        = S_SEND;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MODIFY: begin
                o_cmd.addr_sel = ASEL_VOXEL;
                o_cmd.wr_en    = 1'b1;
                n_state        = S_IDLE;
            end
            S_READ_OUT: begin
                o_cmd.emit_read = 1'b1;
                n_state         = S_IDLE;
            end
            S_CLR_RD: begin
                o_cmd.addr_sel = ASEL_CLEAR;
                o_cmd.rd_en    = 1'b1;
                n_state        = S_CLR_WR;
            end
            S_CLR_WR: begin
                o_cmd.addr_sel = ASEL_CLEAR;
                o_cmd.wr_en    = 1'b1;
                o_cmd.cnt_step = 1'b1;
                n_state        = i_status.clr_done ? S_IDLE : S_CLR_RD;
            end
            S_SEND: begin
                o_cmd.addr_sel  = ASEL_SEND;
                o_cmd.rd_en     = 1'b1;
                o_cmd.cnt_step  = 1'b1;
                o_cmd.emit_word = 1'b1;
                if (i_status.send_done) begin
                    n_state = S_SEND_END;
                end
            end
            S_SEND_END: begin
                o_cmd.emit_word = 1'b1;
                o_cmd.emit_last = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/vcfb_datapath.sv @@
// Datapath for the voxel cube frame buffer: item registers, frame memory,
// entry valid bits, sweep counters and result registers. Depends on vcfb_pkg.
module vcfb_datapath
    import vcfb_pkg::*;
#(
    parameter int CUBE_SIZE = VCFB_CUBE_SIZE,
    parameter int WORD_BITS = VCFB_WORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_col_x,
    input  logic [3:0]  i_row_y,
    input  logic [3:0]  i_layer_z,
    input  logic [3:0]  i_word_index,
    input  logic [15:0] i_word_value,
    input  logic        i_voxel_state,
    output logic        o_strobe,
    output logic        o_result_kind,
    output logic        o_voxel_bit,
    output logic [15:0] o_layer_word,
    output logic        o_last_word
);

    localparam int SIDE  = CUBE_SIZE + 1;
    localparam int DEPTH = SIDE * SIDE;
    localparam int LW    = $clog2(SIDE);
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = WORD_BITS;
    localparam logic [WB-1:0] KEEP_MASK =
        (CUBE_SIZE >= WB) ? '0 : ~((WB'(1) << CUBE_SIZE) - WB'(1));

    logic [2:0]  r_op;
    logic [3:0]  r_x;
    logic [3:0]  r_y;
    logic [3:0]  r_z;
    logic [3:0]  r_wi;
    logic [15:0] r_wv;
    logic        r_st;

    logic [LW-1:0] r_cnt_layer;
    logic [LW-1:0] r_cnt_word;

    logic [WB-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WB-1:0]    r_mem_q;
    logic [WB-1:0]    r_rst_q;
    logic             r_valid_q;

    logic        r_strobe;
    logic        r_kind;
    logic        r_bit;
    logic [15:0] r_word;
    logic        r_last;

    logic [LW-1:0] sel_layer;
    logic [LW-1:0] sel_word;
    logic [AW-1:0] addr;
    logic [WB-1:0] rd_word;
    logic [WB-1:0] rd_shift;
    logic [WB-1:0] voxel_mask;
    logic [WB-1:0] wr_data;

    function automatic logic [WB-1:0] reset_word(input logic [LW-1:0] lay,
                                                 input logic [LW-1:0] wrd);
        logic [WB-1:0] w;
        w = '0;
        if (wrd == LW'(CUBE_SIZE) && lay < LW'(CUBE_SIZE)) begin
            w = WB'(1) << lay;
        end
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_x  <= i_col_x;
            r_y  <= i_row_y;
            r_z  <= i_layer_z;
            r_wi <= i_word_index;
            r_wv <= i_word_value;
            r_st <= i_voxel_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_layer <= '0;
            r_cnt_word  <= '0;
        end else if (i_cmd.load) begin
            r_cnt_layer <= '0;
            r_cnt_word  <= '0;
        end else if (i_cmd.cnt_step) begin
            if (i_cmd.addr_sel == ASEL_CLEAR && r_cnt_word == LW'(CUBE_SIZE - 1)) begin
                r_cnt_word  <= '0;
                r_cnt_layer <= r_cnt_layer + LW'(1);
            end else begin
                r_cnt_word <= r_cnt_word + LW'(1);
            end
        end
    end

    always_comb begin
        o_status.op        = r_op;
        o_status.voxel_ok  = (r_x < 4'(CUBE_SIZE)) && (r_y < 4'(CUBE_SIZE))
                             && (r_z < 4'(CUBE_SIZE));
        o_status.raw_ok    = (r_z <= 4'(CUBE_SIZE)) && (r_wi <= 4'(CUBE_SIZE));
        o_status.send_ok   = (r_z <= 4'(CUBE_SIZE));
        o_status.clr_done  = (r_cnt_layer == LW'(CUBE_SIZE - 1))
                             && (r_cnt_word == LW'(CUBE_SIZE - 1));
        o_status.send_done = (r_cnt_word == LW'(SIDE - 1));
    end

    always_comb begin
        case (i_cmd.addr_sel)
            ASEL_VOXEL: begin
                sel_layer = r_z[LW-1:0];
                sel_word  = LW'(CUBE_SIZE - 1) - r_y[LW-1:0];
            end
            ASEL_RAW: begin
                sel_layer = r_z[LW-1:0];
                sel_word  = r_wi[LW-1:0];
            end
            ASEL_CLEAR: begin
                sel_layer = r_cnt_layer;
                sel_word  = r_cnt_word;
            end
            default: begin
                sel_layer = r_z[LW-1:0];
                sel_word  = r_cnt_word;
            end
        endcase
    end

    assign addr = AW'(sel_layer) * AW'(SIDE) + AW'(sel_word);

    assign rd_word    = r_valid_q ? r_mem_q : r_rst_q;
    assign rd_shift   = rd_word >> r_x;
    assign voxel_mask = WB'(1) << r_x;

    always_comb begin
        case (i_cmd.addr_sel)
            ASEL_VOXEL: begin
                if (r_op == OP_TOGGLE) begin
                    wr_data = rd_word ^ voxel_mask;
                end else if (r_st) begin
                    wr_data = rd_word | voxel_mask;
                end else begin
                    wr_data = rd_word & ~voxel_mask;
                end
            end
            ASEL_RAW: begin
                wr_data = WB'(r_wv);
            end
            default: begin
                wr_data = rd_word & KEEP_MASK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_mem_q <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_valid_q <= r_valid[addr];
            r_rst_q   <= reset_word(sel_layer, sel_word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_en) begin
            r_valid[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_read | i_cmd.emit_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_read) begin
            r_kind <= 1'b0;
            r_bit  <= o_status.voxel_ok & rd_shift[0];
            r_word <= '0;
            r_last <= 1'b0;
        end else if (i_cmd.emit_word) begin
            r_kind <= 1'b1;
            r_bit  <= 1'b0;
            r_word <= 16'(rd_word);
            r_last <= i_cmd.emit_last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_result_kind = r_kind;
    assign o_voxel_bit   = r_bit;
    assign o_layer_word  = r_word;
    assign o_last_word   = r_last;

endmodule

@@ sv/voxel_cube_frame_buffer.sv @@
// Top level of the voxel cube frame buffer.
// Depends on vcfb_pkg, vcfb_ctrl and vcfb_datapath.
//
// A command word is taken at a clock edge where start is high and busy is low.
// Results come out on o_strobe for exactly one cycle each and cannot be held
// off, so the receiver must take every word as it appears. The frame store is
// a single-port memory with a registered read, and busy stays high until the
// command is done. A raw word write is a single write; voxel write, toggle
// and read first read the row word; a layer send reads CUBE_SIZE + 1 words
// and streams them on consecutive cycles; clear all does one read and one
// write for each row word. A write or toggle outside the cube, a send of a
// layer above CUBE_SIZE and an unused operation code go back to idle from
// decode.
module voxel_cube_frame_buffer
    import vcfb_pkg::*;
#(
    parameter int CUBE_SIZE = VCFB_CUBE_SIZE,
    parameter int WORD_BITS = VCFB_WORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_col_x,
    input  logic [3:0]  i_row_y,
    input  logic [3:0]  i_layer_z,
    input  logic [3:0]  i_word_index,
    input  logic [15:0] i_word_value,
    input  logic        i_voxel_state,
    output logic        o_strobe,
    output logic        o_result_kind,
    output logic        o_voxel_bit,
    output logic [15:0] o_layer_word,
    output logic        o_last_word
);

    t_cmd    cmd;
    t_status status;

    vcfb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vcfb_datapath #(
        .CUBE_SIZE (CUBE_SIZE),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (i_operation),
        .i_col_x       (i_col_x),
        .i_row_y       (i_row_y),
        .i_layer_z     (i_layer_z),
        .i_word_index  (i_word_index),
        .i_word_value  (i_word_value),
        .i_voxel_state (i_voxel_state),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_voxel_bit   (o_voxel_bit),
        .o_layer_word  (o_layer_word),
        .o_last_word   (o_last_word)
    );

endmodule
